// ----- hw/rtl/kap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kap_pkg: keypad alarm panel shared types
// Stream payload layouts, the request struct and configuration indexes.
// ----------------------------------------------------------------------------
package kap_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIREN_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASTER_CODE  = 1'b1;

  // input tdata layout, lowest bits last
  typedef struct packed {
    logic [1:0] pad;
    logic       sensor_b;
    logic       sensor_a;
    logic [3:0] key_index;
  } in_data_t;

  // one request as the core sees it
  typedef struct packed {
    logic       func;
    logic [3:0] key_index;
    logic       sensor_a;
    logic       sensor_b;
  } req_t;

  // result tdata layout, lowest bits last
  typedef struct packed {
    logic [3:0] pad;
    logic [1:0] failed_attempts;
    logic [2:0] event_res;
    logic [1:0] keys_entered;
    logic [2:0] entry_phase;
    logic       siren;
    logic       armed;
  } res_t;

endpackage

// ----- hw/rtl/keypad_alarm_panel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_alarm_panel: keypad-driven alarm panel
// Registered request in, one status result out per request.
// ----------------------------------------------------------------------------
// Each request is either a key press (tuser = 0) or a tick carrying two
// sensor samples (tuser = 1), and it yields exactly one status result:
// armed, siren, entry phase, keys entered, an event code and the failed
// attempt count. A request is registered on entry, processed by the panel
// core once the result register is free or draining, and its result lands
// in the output register. One request is taken every cycle while the output
// side keeps up; a waiting result stalls the held request. Configuration
// (siren period, master code) is written through cfg_we_i/cfg_idx_i/cfg_data_i
// by the user only while the panel is idle, which the block does not enforce;
// the siren cutoff of 100 * period is computed at write time.
// ----------------------------------------------------------------------------
module keypad_alarm_panel #(
  parameter int unsigned CODE_KEYS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [kap_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kap_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [kap_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // key_index, sensor_a, sensor_b
  input  logic                               s_axis_tuser,   // func
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [kap_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // armed, siren, entry_phase,
                                                             // keys_entered, event_res,
                                                             // failed_attempts
);
  import kap_pkg::*;

  logic     in_vld_q;
  in_data_t in_data_q;
  logic     in_func_q;
  logic     out_vld_q;
  res_t     out_q;
  logic     proc;
  req_t     req;
  res_t     res;

  // core fires when a request is held and the result slot is free or draining
  assign proc          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || proc;

  always_comb begin
    req.func      = in_func_q;
    req.key_index = in_data_q.key_index;
    req.sensor_a  = in_data_q.sensor_a;
    req.sensor_b  = in_data_q.sensor_b;
  end

  kap_core #(
    .CODE_KEYS (CODE_KEYS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_vld_i  (proc),
    .req_i      (req),
    .res_o      (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= in_data_t'(s_axis_tdata);
      in_func_q <= s_axis_tuser;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- hw/rtl/kap_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kap_core: panel state and per-request update
// Holds config, code buffers and siren timer; updates them for one request.
// ----------------------------------------------------------------------------
module kap_core #(
  parameter int unsigned CODE_KEYS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kap_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kap_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               req_vld_i,
  input  kap_pkg::req_t                      req_i,
  output kap_pkg::res_t                      res_o
);
  import kap_pkg::*;

  localparam int unsigned CODE_W = 4 * CODE_KEYS;
  localparam int unsigned KCW    = $clog2(CODE_KEYS + 1);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_USER    = 3'd1;
  localparam logic [2:0] PH_MASTER  = 3'd2;
  localparam logic [2:0] PH_NEW     = 3'd3;
  localparam logic [2:0] PH_CONFIRM = 3'd4;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_ARMED    = 3'd1;
  localparam logic [2:0] EV_DISARMED = 3'd2;
  localparam logic [2:0] EV_WRONG    = 3'd3;
  localparam logic [2:0] EV_LOCKOUT  = 3'd4;
  localparam logic [2:0] EV_CHANGED  = 3'd5;
  localparam logic [2:0] EV_MISMATCH = 3'd6;
  localparam logic [2:0] EV_REJECTED = 3'd7;

  localparam logic [1:0] LOCKOUT_AT = 2'd2;  // third miss locks out

  localparam logic [CODE_W+15:0] MASTER_RST_EXT = {{CODE_W{1'b0}}, 16'h1111};
  localparam logic [CODE_W+15:0] USER_RST_EXT   = {{CODE_W{1'b0}}, 16'h4EC5};
  localparam logic [14:0]        CUTOFF_RST     = 15'd600;

  function automatic logic is_digit(input logic [3:0] k);
    case (k)
      4'd1, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10, 4'd12, 4'd13, 4'd14: is_digit = 1'b1;
      default: is_digit = 1'b0;
    endcase
  endfunction

  // state
  logic              armed_q, armed_d;
  logic              siren_q, siren_d;
  logic [1:0]        att_q, att_d;
  logic [14:0]       ticks_q, ticks_d;
  logic [2:0]        phase_q, phase_d;
  logic [KCW-1:0]    kc_q, kc_d;
  logic [CODE_W-1:0] ebuf_q, ebuf_d;
  logic [CODE_W-1:0] nbuf_q, nbuf_d;
  logic [CODE_W-1:0] ucode_q, ucode_d;
  logic [CODE_W-1:0] master_q, master_d;
  logic [14:0]       cutoff_q, cutoff_d;
  logic [2:0]        ev;

  // key collection
  logic [CODE_W-1:0] col_src, col_buf;
  logic [CODE_W+3:0] col_ext;
  logic [KCW:0]      kc_inc;
  logic              col_done;
  logic [KCW+1:0]    kc_ext;

  // config decode; cutoff = 100 * period, done with shifts
  logic [14:0]         per15;
  logic [CODE_W+15:0]  mst_ext;

  always_comb begin
    per15    = {7'd0, cfg_data_i[7:0]};
    mst_ext  = {{CODE_W{1'b0}}, cfg_data_i};
    cutoff_d = cutoff_q;
    master_d = master_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIREN_PERIOD: cutoff_d = (per15 << 6) + (per15 << 5) + (per15 << 2);
        CFG_MASTER_CODE:  master_d = mst_ext[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_src  = (phase_q == PH_NEW) ? nbuf_q : ebuf_q;
    col_ext  = {col_src, req_i.key_index};
    col_buf  = col_ext[CODE_W-1:0];
    kc_inc   = {1'b0, kc_q} + (KCW+1)'(1);
    col_done = (kc_inc >= (KCW+1)'(CODE_KEYS));
  end

  always_comb begin
    armed_d = armed_q;
    siren_d = siren_q;
    att_d   = att_q;
    ticks_d = ticks_q;
    phase_d = phase_q;
    kc_d    = kc_q;
    ebuf_d  = ebuf_q;
    nbuf_d  = nbuf_q;
    ucode_d = ucode_q;
    ev      = EV_NONE;

    if (!req_i.func) begin
      if (phase_q != PH_IDLE) begin
        kc_d = col_done ? '0 : kc_inc[KCW-1:0];
      end
      case (phase_q)
        PH_IDLE: begin
          if (req_i.key_index == 4'd0) begin
            phase_d = PH_MASTER;
            kc_d    = '0;
            ebuf_d  = '0;
          end else if (is_digit(req_i.key_index)) begin
            phase_d = PH_USER;
            kc_d    = '0;
            ebuf_d  = '0;
          end
        end
        PH_USER: begin
          ebuf_d = col_buf;
          if (col_done) begin
            phase_d = PH_IDLE;
            if (col_buf == ucode_q) begin
              armed_d = !armed_q;
              att_d   = '0;
              ev      = armed_q ? EV_DISARMED : EV_ARMED;
            end else if (att_q == LOCKOUT_AT) begin
              att_d = '0;
              ev    = EV_LOCKOUT;
            end else begin
              att_d = att_q + 2'd1;
              ev    = EV_WRONG;
            end
          end
        end
        PH_MASTER: begin
          ebuf_d = col_buf;
          if (col_done) begin
            if (col_buf == master_q) begin
              phase_d = PH_NEW;
              nbuf_d  = '0;
            end else begin
              phase_d = PH_IDLE;
              ev      = EV_REJECTED;
            end
          end
        end
        PH_NEW: begin
          nbuf_d = col_buf;
          if (col_done) begin
            phase_d = PH_CONFIRM;
            ebuf_d  = '0;
          end
        end
        default: begin
          ebuf_d = col_buf;
          if (col_done) begin
            phase_d = PH_IDLE;
            if (col_buf == nbuf_q) begin
              ucode_d = nbuf_q;
              ev      = EV_CHANGED;
            end else begin
              ev = EV_MISMATCH;
            end
          end
        end
      endcase
    end else if (armed_q) begin
      if (req_i.sensor_a || req_i.sensor_b) begin
        siren_d = 1'b1;
      end
      if (ticks_q >= cutoff_q) begin
        siren_d = 1'b0;
        ticks_d = 15'd1;
      end else begin
        ticks_d = ticks_q + 15'd1;
      end
    end

    if (!armed_d) begin
      siren_d = 1'b0;
    end
  end

  always_comb begin
    kc_ext                = {2'b00, kc_d};
    res_o                 = '0;
    res_o.armed           = armed_d;
    res_o.siren           = siren_d;
    res_o.entry_phase     = phase_d;
    res_o.keys_entered    = kc_ext[1:0];
    res_o.event_res       = ev;
    res_o.failed_attempts = att_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RST;
      master_q <= MASTER_RST_EXT[CODE_W-1:0];
    end else begin
      cutoff_q <= cutoff_d;
      master_q <= master_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      siren_q <= 1'b0;
      att_q   <= '0;
      ticks_q <= '0;
      phase_q <= PH_IDLE;
      kc_q    <= '0;
      ebuf_q  <= '0;
      nbuf_q  <= '0;
      ucode_q <= USER_RST_EXT[CODE_W-1:0];
    end else if (req_vld_i) begin
      armed_q <= armed_d;
      siren_q <= siren_d;
      att_q   <= att_d;
      ticks_q <= ticks_d;
      phase_q <= phase_d;
      kc_q    <= kc_d;
      ebuf_q  <= ebuf_d;
      nbuf_q  <= nbuf_d;
      ucode_q <= ucode_d;
    end
  end

endmodule
